// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// shared types and constants of the huffman code bit packer
// ----------------------------------------------------------------------------
package hcbp_pkg;

    // operation codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    // field and datapath widths
    localparam int CODE_W      = 31;
    localparam int BITS_W      = 30;
    localparam int LEN_W       = 5;
    localparam int BUF_W       = 40;
    localparam int QUEUE_DEPTH = 4;

    // input transfer payload
    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        symbol;
        logic [CODE_W-1:0] code_word;
    } t_in_item;

    // output transfer payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    // job handed from front to back; bits are msb first, bits[BITS_W-1] goes out first
    typedef struct packed {
        logic              is_flush;
        logic [BITS_W-1:0] bits;
        logic [LEN_W-1:0]  len;
    } t_job;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== sv/hcbp_ram.sv =====
// ----------------------------------------------------------------------------
// hcbp_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module hcbp_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read, read data holds without a read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/hcbp_queue.sv =====
// ----------------------------------------------------------------------------
// hcbp_queue
// short job fifo between the front and back ends
// ----------------------------------------------------------------------------
module hcbp_queue
    import hcbp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_head, r_tail;
    logic [CNT_W-1:0] r_count;

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= PTR_W'((32'(r_tail) + 1) % QUEUE_DEPTH);
            end
            if (i_pop) begin
                r_head <= PTR_W'((32'(r_head) + 1) % QUEUE_DEPTH);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_job        = r_mem[r_head];
    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// ===== sv/hcbp_front.sv =====
// ----------------------------------------------------------------------------
// hcbp_front
// accepts items, keeps the code table, turns codes into msb-first jobs
// ----------------------------------------------------------------------------
module hcbp_front
    import hcbp_pkg::*;
#(
    parameter int SYMBOLS      = 256,
    parameter int MAX_CODE_LEN = 30
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_data,
    input  t_q_stat  i_q_stat,
    output logic     o_push,
    output t_job     o_job
);

    localparam int ADDR_W = $clog2(SYMBOLS);

    logic              accept;
    logic              in_range;
    logic              needs_push;
    logic [CODE_W-1:0] rdata;
    logic [LEN_W-1:0]  len_raw;
    logic [LEN_W-1:0]  len_eff;

    // stage one: item whose table read is in flight
    logic       r_s1_valid;
    logic [1:0] r_s1_op;
    logic       r_s1_in_range;

    assign in_range = ({1'b0, i_data.symbol} < 9'(SYMBOLS));
    assign accept   = i_valid && o_ready;

    // code table
    hcbp_ram #(
        .WIDTH (CODE_W),
        .DEPTH (SYMBOLS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (accept && (i_data.op == OP_LOAD) && in_range),
        .i_re    (accept && (i_data.op == OP_ENCODE) && in_range),
        .i_addr  (i_data.symbol[ADDR_W-1:0]),
        .i_wdata (i_data.code_word),
        .o_rdata (rdata)
    );

    // only flushes and encodes with a real code reach the back end
    always_comb begin
        needs_push = 1'b0;
        if (r_s1_valid) begin
            case (r_s1_op)
                OP_FLUSH:  needs_push = 1'b1;
                OP_ENCODE: needs_push = r_s1_in_range && (|rdata[CODE_W-1:1]);
                default:   needs_push = 1'b0;
            endcase
        end
    end

    assign o_push  = needs_push && !i_q_stat.full;
    assign o_ready = !r_s1_valid || !needs_push || !i_q_stat.full;

    // code length from the sentinel bit, capped
    always_comb begin
        len_raw = '0;
        for (int i = 1; i < CODE_W; i++) begin
            if (rdata[i]) begin
                len_raw = LEN_W'(i);
            end
        end
        if ({1'b0, len_raw} > 6'(MAX_CODE_LEN)) begin
            len_eff = LEN_W'(MAX_CODE_LEN);
        end else begin
            len_eff = len_raw;
        end
    end

    // job: code bits reversed into msb-first order, bits past the length cleared
    always_comb begin
        o_job.is_flush = (r_s1_op == OP_FLUSH);
        o_job.len      = len_eff;
        for (int k = 0; k < BITS_W; k++) begin
            o_job.bits[BITS_W-1-k] = rdata[k] && (k < int'(len_eff));
        end
    end

    // stage one control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op       <= i_data.op;
            r_s1_in_range <= in_range;
        end
    end

endmodule

// ===== sv/hcbp_back.sv =====
// ----------------------------------------------------------------------------
// hcbp_back
// bit packer: merges jobs into the partial byte and sends whole bytes
// ----------------------------------------------------------------------------
module hcbp_back
    import hcbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic [7:0]       r_partial, n_partial;
    logic [2:0]       r_count, n_count;
    logic [2:0]       r_nbytes, n_nbytes;
    logic [BUF_W-1:0] r_buf, n_buf;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             emit;
    logic [3:0]       shamt;
    logic [BUF_W-1:0] placed;
    logic [5:0]       total;

    assign o_pop = (r_nbytes == '0) && !i_q_stat.empty;
    assign emit  = (r_nbytes != '0) && (!r_out_valid || i_ready);

    // new bits lined up right after the pending ones
    assign shamt  = 4'd8 - {1'b0, r_count};
    assign placed = {8'b0, i_job.bits, 2'b0} << shamt;
    assign total  = {3'b0, r_count} + {1'b0, i_job.len};

    // next state for job start and byte shifting
    always_comb begin
        n_partial = r_partial;
        n_count   = r_count;
        n_nbytes  = r_nbytes;
        n_buf     = r_buf;
        if (o_pop) begin
            if (i_job.is_flush) begin
                n_buf    = {r_partial, 32'b0};
                n_nbytes = {2'b0, (r_count != '0)};
                n_count  = '0;
            end else begin
                n_buf    = {r_partial, 32'b0} | placed;
                n_nbytes = total[5:3];
                n_count  = total[2:0];
                if (total[5:3] == '0) begin
                    n_partial = n_buf[BUF_W-1 -: 8];
                end
            end
        end else if (emit) begin
            n_buf    = r_buf << 8;
            n_nbytes = r_nbytes - 3'd1;
            if (r_nbytes == 3'd1) begin
                n_partial = r_buf[BUF_W-9 -: 8];
            end
        end
    end

    // control and packer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial   <= '0;
            r_count     <= '0;
            r_nbytes    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_partial <= n_partial;
            r_count   <= n_count;
            r_nbytes  <= n_nbytes;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (emit) begin
            r_out.out_byte    <= r_buf[BUF_W-1 -: 8];
            r_out.last_of_run <= (r_nbytes == 3'd1);
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== sv/huffman_code_bit_packer_top.sv =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_top
// path: the first byte of an encode or flush passes the table read, the job queue,
// the packer buffer and the output register; the packer takes a new job only once
// all bytes of the last job are sent; loads and empty codes never reach it
// up to four jobs queue between table lookup and packer
// reset: control and the partial byte clear at once; the code table is not cleared
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module huffman_code_bit_packer_top
    import hcbp_pkg::*;
#(
    parameter int SYMBOLS      = 256,
    parameter int MAX_CODE_LEN = 30
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic    push, pop;
    t_job    push_job, pop_job;
    t_q_stat q_stat;

    // table lookup and job build
    hcbp_front #(
        .SYMBOLS      (SYMBOLS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (push_job)
    );

    // job queue
    hcbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_stat  (q_stat)
    );

    // bit packer
    hcbp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (pop_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data)
    );

    // queue never overruns or underruns, and a run of bytes has no gaps
    `ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, push, !q_stat.full)
    `ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, pop, !q_stat.empty)
    `ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, o_valid && !o_data.last_of_run, o_valid)

endmodule
